>>> src/pale_pkg.sv
// shared types and codes for the positional array list engine
// no dependencies; imported by pale_cell and the top level
package pale_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_LOCATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   word;
  } cell_cmd_t;

endpackage

>>> src/pale_cell.sv
// one list slot: holds a word and takes it from a neighbour, the head or the input word
// depends on pale_pkg
module pale_cell
  import pale_pkg::*;
#(
  parameter int CW  = 8,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CW-1:0]     sel,
  input  logic [CW-1:0]     last,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  input  logic [WORD_W-1:0] head_word,
  output logic [WORD_W-1:0] word
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > sel) begin
          word_nxt = left_word;
        end else if (MY_IDX == sel) begin
          word_nxt = cmd.word;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= sel) begin
          word_nxt = right_word;
        end
      end
      CELL_ROTATE: begin
        if (MY_IDX < last) begin
          word_nxt = right_word;
        end else if (MY_IDX == last) begin
          word_nxt = head_word;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

>>> src/positional_array_list_engine.sv
// top level: sequencer and a chain of pale_cell slots holding the list
// depends on pale_pkg and pale_cell
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-------------------------
//  input   | in_mode, in_position, in_item_value                | start high, busy low
//  result  | out_ok, out_read_value, out_found_position,        | out_valid, one cycle,
//          | out_list_length                                    | cannot be held off
//
// insert, every rejected operation and locate on an empty list: result registered in
//   the cycle after the word is taken, busy stays low, so a word can be taken every cycle
// read and locate: the list is rotated once through the cell chain past cell 0
//   and compared there; delete does the same, then adds the SHIFT state for the shift down
// synchronous active-low reset empties the list; slot contents are not cleared
module positional_array_list_engine
  import pale_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_length
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     sel_r, sel_nxt;
  mode_t             mode_r, mode_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  logic              hit_r, hit_nxt;
  logic [XW-1:0]     found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [WORD_W-1:0] out_rd_r, out_rd_nxt;
  logic [XW-1:0]     out_found_r, out_found_nxt;
  logic [XW-1:0]     out_len_r, out_len_nxt;

  logic              accept;
  mode_t             in_mode_e;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [CW-1:0]     sel_in;
  logic              pos_ok_rd;
  logic              pos_ok_ins;
  logic [CW-1:0]     last_idx;
  logic              last_step;
  logic [WORD_W-1:0] head;
  logic              head_hit;

  cell_cmd_t         cmd;
  logic [CW-1:0]     cell_sel;
  logic [WORD_W-1:0] cell_word [DEPTH];

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_mode_e = mode_t'(in_mode);

  assign pos_x      = XW'(in_position);
  assign cnt_x      = XW'(count_r);
  assign sel_in     = CW'(pos_x - XW'(1));
  assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
  assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (count_r != CW'(DEPTH));

  assign last_idx  = count_r - CW'(1);
  assign last_step = (k_r == last_idx);
  assign head      = cell_word[0];
  assign head_hit  = (head == key_r);

  // cell chain command
  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.word = in_item_value;
    cell_sel = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        cell_sel = sel_in;
        if (accept && (in_mode_e == MODE_INSERT) && pos_ok_ins) begin
          cmd.op = CELL_INSERT;
        end
      end
      ST_SCAN:  cmd.op = CELL_ROTATE;
      ST_SHIFT: cmd.op = CELL_DELETE;
      default:  cmd.op = CELL_HOLD;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    sel_nxt       = sel_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    rd_nxt        = rd_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    out_found_nxt = out_found_r;
    out_len_nxt   = out_len_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_mode_e;
          sel_nxt   = sel_in;
          key_nxt   = in_item_value;
          k_nxt     = '0;
          rd_nxt    = '0;
          hit_nxt   = 1'b0;
          found_nxt = '0;
          out_ok_nxt    = 1'b0;
          out_rd_nxt    = '0;
          out_found_nxt = '0;
          out_len_nxt   = cnt_x;
          unique case (in_mode_e)
            MODE_INSERT: begin
              out_valid_nxt = 1'b1;
              if (pos_ok_ins) begin
                count_nxt   = count_r + CW'(1);
                out_ok_nxt  = 1'b1;
                out_len_nxt = cnt_x + XW'(1);
              end
            end
            MODE_DELETE, MODE_READ: begin
              if (pos_ok_rd) begin
                state_nxt = ST_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        k_nxt = k_r + CW'(1);
        if ((mode_r != MODE_LOCATE) && (k_r == sel_r)) begin
          rd_nxt = head;
        end
        if ((mode_r == MODE_LOCATE) && !hit_r && head_hit) begin
          hit_nxt   = 1'b1;
          found_nxt = XW'(k_r) + XW'(1);
        end
        if (last_step) begin
          if (mode_r == MODE_DELETE) begin
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            out_rd_nxt    = (mode_r == MODE_READ) ? rd_nxt : '0;
            out_found_nxt = (mode_r == MODE_LOCATE) ? found_nxt : '0;
            out_len_nxt   = cnt_x;
          end
        end
      end
      ST_SHIFT: begin
        state_nxt     = ST_IDLE;
        count_nxt     = count_r - CW'(1);
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_rd_nxt    = rd_r;
        out_found_nxt = '0;
        out_len_nxt   = cnt_x - XW'(1);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    sel_r       <= sel_nxt;
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    rd_r        <= rd_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    out_ok_r    <= out_ok_nxt;
    out_rd_r    <= out_rd_nxt;
    out_found_r <= out_found_nxt;
    out_len_r   <= out_len_nxt;
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_word[i+1];
    end

    pale_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel        (cell_sel),
      .last       (last_idx),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (head),
      .word       (cell_word[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r[7:0];
  assign out_list_length    = out_len_r[7:0];

endmodule
